// File: hdl/rlc_pkg.sv
// Package for the RGB LED effect colour engine: types, constants and
// small arithmetic helpers. No dependencies.
package rlc_pkg;

  localparam int unsigned RLC_PWM_LEVELS = 64;

  // Divide by 100 as multiply by the reciprocal and shift.
  localparam int unsigned RLC_REC_SHIFT = 26;
  localparam logic [19:0] RLC_REC_100 = 20'd671089;

  typedef enum logic [1:0] {
    MODE_SOLID     = 2'd0,
    MODE_FADE      = 2'd1,
    MODE_RAINBOW   = 2'd2,
    MODE_SOLID_ALT = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    REG_EFFECT_MODE    = 3'd0,
    REG_COLOUR_ONE     = 3'd1,
    REG_COLOUR_TWO     = 3'd2,
    REG_GAIN_SET       = 3'd3,
    REG_BRIGHTNESS     = 3'd4,
    REG_MAX_BRIGHTNESS = 3'd5,
    REG_CYCLE_SECONDS  = 3'd6,
    REG_ENABLED        = 3'd7
  } reg_idx_e;

  // Per-channel vector: index 2 is red, 1 green, 0 blue, matching the packing.
  typedef logic [2:0][7:0] rgb_t;

  // Exact floor(x / 255) for any 16-bit x.
  function automatic logic [8:0] div255(input logic [15:0] x);
    logic [16:0] y;
    logic [16:0] s;
    y = {1'b0, x} + 17'd1;
    s = y + (y >> 8);
    return s[16:8];
  endfunction

  function automatic logic [7:0] sq_gamma(input logic [7:0] v);
    logic [15:0] p;
    logic [8:0]  q;
    p = 16'(v) * 16'(v) + 16'd127;
    q = div255(p);
    return q[7:0];
  endfunction

  function automatic rgb_t wheel(input logic [7:0] pos);
    logic [7:0] p;
    logic [9:0] p3;
    rgb_t       c;
    if (pos < 8'd85) begin
      p3 = 10'(pos) * 10'd3;
      c  = {8'd255 - p3[7:0], p3[7:0], 8'd0};
    end else if (pos < 8'd170) begin
      p  = pos - 8'd85;
      p3 = 10'(p) * 10'd3;
      c  = {8'd0, 8'd255 - p3[7:0], p3[7:0]};
    end else begin
      p  = pos - 8'd170;
      p3 = 10'(p) * 10'd3;
      c  = {p3[7:0], 8'd0, 8'd255 - p3[7:0]};
    end
    return c;
  endfunction

endpackage

// File: hdl/rlc_mod_pipe.sv
// Pipelined remainder unit: phase = elapsed_ms mod cycle, four bits per stage.
// Depends on rlc_pkg.
module rlc_mod_pipe import rlc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        adv_i,
  input  logic        valid_i,
  input  logic [31:0] time_i,
  input  logic [15:0] cycle_i,
  output logic        valid_o,
  output logic [15:0] phase_o
);

  localparam int unsigned NStg = 8;
  localparam int unsigned Bps  = 32 / NStg;

  logic [NStg-1:0] v_q;
  logic [15:0]     rem_q [NStg];
  logic [15:0]     rem_d [NStg];
  logic [31:0]     t_q   [NStg];
  logic [31:0]     t_d   [NStg];

  always_comb begin
    logic [16:0] r;
    logic [31:0] tt;
    for (int s = 0; s < NStg; s++) begin
      r  = (s == 0) ? 17'd0 : {1'b0, rem_q[(s == 0) ? 0 : s - 1]};
      tt = (s == 0) ? time_i : t_q[(s == 0) ? 0 : s - 1];
      for (int j = 0; j < Bps; j++) begin
        r  = {r[15:0], tt[31]};
        tt = tt << 1;
        if (r >= {1'b0, cycle_i}) r = r - {1'b0, cycle_i};
      end
      rem_d[s] = r[15:0];
      t_d[s]   = tt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv_i) begin
      v_q <= {v_q[NStg-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      for (int s = 0; s < NStg; s++) begin
        rem_q[s] <= rem_d[s];
        t_q[s]   <= t_d[s];
      end
    end
  end

  assign valid_o = v_q[NStg-1];
  assign phase_o = rem_q[NStg-1];

endmodule

// File: hdl/rlc_div_pipe.sv
// Fade mix and wheel position: builds numerators, then divides them in two
// stages of four quotient bits. Depends on rlc_pkg.
module rlc_div_pipe import rlc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        adv_i,
  input  logic        valid_i,
  input  logic [15:0] phase_i,
  input  logic [15:0] cycle_i,
  input  logic [14:0] half_i,
  input  rgb_t        col_one_i,
  input  rgb_t        col_two_i,
  input  rgb_t        gam_one_i,
  input  rgb_t        gam_two_i,
  output logic        valid_o,
  output rgb_t        mix_raw_o,
  output rgb_t        mix_lin_o,
  output logic [7:0]  pos_o
);

  localparam int unsigned NLane = 7;
  localparam int unsigned WheelLane = 6;

  logic [2:0]  v_q;
  logic [23:0] num_q [NLane];
  logic [23:0] num_d [NLane];
  logic [23:0] rem_q [NLane];
  logic [23:0] rem_d [NLane];
  logic [3:0]  qh_q  [NLane];
  logic [3:0]  qh_d  [NLane];
  logic [7:0]  q_q   [NLane];
  logic [7:0]  q_d   [NLane];
  logic [23:0] dvs   [NLane];

  always_comb begin
    logic [15:0] amt;
    logic [14:0] rest;
    logic [7:0]  a;
    logic [7:0]  b;
    // The fade amount rises to half a cycle and falls back.
    amt  = (phase_i <= {1'b0, half_i}) ? phase_i : cycle_i - phase_i;
    rest = half_i - amt[14:0];
    for (int k = 0; k < 6; k++) begin
      a = (k < 3) ? col_one_i[k % 3] : gam_one_i[k % 3];
      b = (k < 3) ? col_two_i[k % 3] : gam_two_i[k % 3];
      num_d[k] = 24'(a) * 24'(rest) + 24'(b) * 24'(amt[14:0]) + 24'(half_i >> 1);
      dvs[k]   = 24'(half_i);
    end
    num_d[WheelLane] = 24'(phase_i) * 24'd255;
    dvs[WheelLane]   = 24'(cycle_i);
  end

  always_comb begin
    logic [23:0] r;
    for (int k = 0; k < NLane; k++) begin
      r = num_q[k];
      for (int i = 7; i >= 4; i--) begin
        qh_d[k][i-4] = (r >= (dvs[k] << i));
        if (qh_d[k][i-4]) r = r - (dvs[k] << i);
      end
      rem_d[k] = r;
      r = rem_q[k];
      for (int i = 3; i >= 0; i--) begin
        q_d[k][i] = (r >= (dvs[k] << i));
        if (q_d[k][i]) r = r - (dvs[k] << i);
      end
      q_d[k][7:4] = qh_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv_i) begin
      v_q <= {v_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      for (int k = 0; k < NLane; k++) begin
        num_q[k] <= num_d[k];
        rem_q[k] <= rem_d[k];
        qh_q[k]  <= qh_d[k];
        q_q[k]   <= q_d[k];
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      mix_raw_o[k] = q_q[k];
      mix_lin_o[k] = q_q[k+3];
    end
  end

  assign valid_o = v_q[2];
  assign pos_o   = q_q[WheelLane];

endmodule

// File: hdl/rlc_drive.sv
// Four-stage duty scaler: brightness percent, then gain percent, saturated,
// and forced to zero when disabled. Depends on rlc_pkg.
module rlc_drive import rlc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       adv_i,
  input  logic       valid_i,
  input  rgb_t       lin_i,
  input  rgb_t       gain_i,
  input  logic [7:0] eff_i,
  input  logic       enable_i,
  output logic       valid_o,
  output rgb_t       duty_o
);

  logic [3:0]        v_q;
  logic [2:0][15:0]  x1_q;
  logic [2:0][9:0]   o1_q;
  logic [2:0][17:0]  x2_q;
  rgb_t              duty_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv_i) begin
      v_q <= {v_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    logic [35:0] p1;
    logic [37:0] p2;
    logic [11:0] o2;
    if (adv_i) begin
      for (int c = 0; c < 3; c++) begin
        x1_q[c] <= 16'(lin_i[c]) * 16'(eff_i) + 16'd50;
        p1       = 36'(x1_q[c]) * 36'(RLC_REC_100);
        o1_q[c] <= p1[RLC_REC_SHIFT+9:RLC_REC_SHIFT];
        x2_q[c] <= 18'(o1_q[c]) * 18'(gain_i[c]) + 18'd50;
        p2       = 38'(x2_q[c]) * 38'(RLC_REC_100);
        o2       = p2[RLC_REC_SHIFT+11:RLC_REC_SHIFT];
        duty_q[c] <= !enable_i ? 8'd0 : (o2 > 12'd255) ? 8'd255 : o2[7:0];
      end
    end
  end

  assign valid_o = v_q[3];
  assign duty_o  = duty_q;

endmodule

// File: hdl/rgb_led_effect_colour_engine.sv
// RGB LED effect colour engine, top level. One item is accepted per cycle
// when the output side keeps up. The whole pipeline stalls together while
// a result waits. Reset returns the registers to their defaults and empties
// the pipe.
// Depends on rlc_pkg, rlc_mod_pipe, rlc_div_pipe and rlc_drive.
module rgb_led_effect_colour_engine import rlc_pkg::*; #(
  parameter int unsigned PWM_LEVELS = RLC_PWM_LEVELS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] elapsed_ms_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  raw_red_o,
  output logic [7:0]  raw_green_o,
  output logic [7:0]  raw_blue_o,
  output logic [7:0]  duty_red_o,
  output logic [7:0]  duty_green_o,
  output logic [7:0]  duty_blue_o,
  output logic [7:0]  level_red_o,
  output logic [7:0]  level_green_o,
  output logic [7:0]  level_blue_o,
  output logic        stays_dark_o
);

  localparam logic [7:0] Levels = 8'(PWM_LEVELS);

  mode_e       mode_q;
  rgb_t        col_one_q, col_two_q, gain_q;
  logic [7:0]  bri_q, maxb_q, cyc_q;
  logic        en_q;
  reg_idx_e    idx;
  logic        wr;

  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[4:2]);
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_SOLID;
      col_one_q <= '0;
      col_two_q <= '0;
      gain_q    <= 24'h646464;
      bri_q     <= 8'd100;
      maxb_q    <= 8'd100;
      cyc_q     <= 8'd0;
      en_q      <= 1'b1;
    end else if (wr) begin
      unique case (idx)
        REG_EFFECT_MODE:    mode_q    <= mode_e'(pwdata[1:0]);
        REG_COLOUR_ONE:     col_one_q <= pwdata[23:0];
        REG_COLOUR_TWO:     col_two_q <= pwdata[23:0];
        REG_GAIN_SET:       gain_q    <= pwdata[23:0];
        REG_BRIGHTNESS:     bri_q     <= pwdata[7:0];
        REG_MAX_BRIGHTNESS: maxb_q    <= pwdata[7:0];
        REG_CYCLE_SECONDS:  cyc_q     <= pwdata[7:0];
        REG_ENABLED:        en_q      <= pwdata[0];
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_EFFECT_MODE:    prdata = 32'(mode_q);
      REG_COLOUR_ONE:     prdata = 32'(col_one_q);
      REG_COLOUR_TWO:     prdata = 32'(col_two_q);
      REG_GAIN_SET:       prdata = 32'(gain_q);
      REG_BRIGHTNESS:     prdata = 32'(bri_q);
      REG_MAX_BRIGHTNESS: prdata = 32'(maxb_q);
      REG_CYCLE_SECONDS:  prdata = 32'(cyc_q);
      REG_ENABLED:        prdata = 32'(en_q);
    endcase
  end

  // Values derived from the configuration.
  logic [5:0]  secs;
  logic [15:0] cycle;
  logic [14:0] half;
  logic [7:0]  eff;
  rgb_t        gam_one_q, gam_two_q;

  always_comb begin
    if (cyc_q < 8'd2) secs = (mode_q == MODE_RAINBOW) ? 6'd12 : 6'd8;
    else if (cyc_q > 8'd60) secs = 6'd60;
    else secs = cyc_q[5:0];
  end

  assign cycle = 16'(secs) * 16'd1000;
  assign half  = cycle[15:1];
  assign eff   = (bri_q < maxb_q) ? bri_q : maxb_q;

  always_ff @(posedge clk_i) begin
    for (int c = 0; c < 3; c++) begin
      gam_one_q[c] <= sq_gamma(col_one_q[c]);
      gam_two_q[c] <= sq_gamma(col_two_q[c]);
    end
  end

  // The whole pipeline moves together whenever the output register is free.
  logic adv;
  assign adv        = !out_valid_o || out_ready_i;
  assign in_ready_o = adv;

  logic        v_mod;
  logic [15:0] phase;

  rlc_mod_pipe u_mod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (in_valid_i),
    .time_i  (elapsed_ms_i),
    .cycle_i (cycle),
    .valid_o (v_mod),
    .phase_o (phase)
  );

  logic       v_div;
  rgb_t       mix_raw, mix_lin;
  logic [7:0] pos;

  rlc_div_pipe u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .adv_i     (adv),
    .valid_i   (v_mod),
    .phase_i   (phase),
    .cycle_i   (cycle),
    .half_i    (half),
    .col_one_i (col_one_q),
    .col_two_i (col_two_q),
    .gam_one_i (gam_one_q),
    .gam_two_i (gam_two_q),
    .valid_o   (v_div),
    .mix_raw_o (mix_raw),
    .mix_lin_o (mix_lin),
    .pos_o     (pos)
  );

  logic v_w_q, v_g_q;
  logic fade_w_q;
  rgb_t raw_w_d, raw_w_q, mlin_w_q, raw_g_q, lin_g_q;

  always_comb begin
    unique case (mode_q)
      MODE_FADE:                  raw_w_d = mix_raw;
      MODE_RAINBOW:               raw_w_d = wheel(pos);
      MODE_SOLID, MODE_SOLID_ALT: raw_w_d = col_one_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_w_q <= 1'b0;
      v_g_q <= 1'b0;
    end else if (adv) begin
      v_w_q <= v_div;
      v_g_q <= v_w_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      raw_w_q  <= raw_w_d;
      mlin_w_q <= mix_lin;
      fade_w_q <= (mode_q == MODE_FADE);
      raw_g_q  <= raw_w_q;
      for (int c = 0; c < 3; c++) begin
        lin_g_q[c] <= fade_w_q ? mlin_w_q[c] : sq_gamma(raw_w_q[c]);
      end
    end
  end

  logic v_drv;
  rgb_t duty;

  rlc_drive u_drive (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (adv),
    .valid_i  (v_g_q),
    .lin_i    (lin_g_q),
    .gain_i   (gain_q),
    .eff_i    (eff),
    .enable_i (en_q),
    .valid_o  (v_drv),
    .duty_o   (duty)
  );

  // Raw colour travels alongside the duty scaler.
  rgb_t raw_dly_q [4];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      raw_dly_q[0] <= raw_g_q;
      for (int s = 1; s < 4; s++) raw_dly_q[s] <= raw_dly_q[s-1];
    end
  end

  // The dark flag depends only on configuration, so it is computed by two
  // free-running scalers that settle long before an item reaches the output.
  rgb_t duty_one, duty_two;
  logic dark_q;

  rlc_drive u_dark_one (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (1'b1),
    .valid_i  (1'b1),
    .lin_i    (gam_one_q),
    .gain_i   (gain_q),
    .eff_i    (eff),
    .enable_i (1'b1),
    .valid_o  (),
    .duty_o   (duty_one)
  );

  rlc_drive u_dark_two (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (1'b1),
    .valid_i  (1'b1),
    .lin_i    (gam_two_q),
    .gain_i   (gain_q),
    .eff_i    (eff),
    .enable_i (1'b1),
    .valid_o  (),
    .duty_o   (duty_two)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dark_q <= 1'b1;
    end else if (!en_q || bri_q == 8'd0 || maxb_q == 8'd0) begin
      dark_q <= 1'b1;
    end else if (mode_q == MODE_RAINBOW) begin
      dark_q <= (gain_q == '0);
    end else begin
      dark_q <= !((|duty_one) || (mode_q == MODE_FADE && (|duty_two)));
    end
  end

  // Output register with PWM level quantization.
  logic out_v_q;
  rgb_t raw_o_q, duty_o_q, level_o_q;
  logic dark_o_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (adv) begin
      out_v_q <= v_drv;
    end
  end

  always_ff @(posedge clk_i) begin
    logic [15:0] p;
    logic [8:0]  lv;
    if (adv) begin
      raw_o_q  <= raw_dly_q[3];
      duty_o_q <= duty;
      dark_o_q <= dark_q;
      for (int c = 0; c < 3; c++) begin
        p  = 16'(duty[c]) * 16'(Levels) + 16'd127;
        lv = div255(p);
        if (duty[c] == 8'd0) level_o_q[c] <= 8'd0;
        else if (lv == 9'd0) level_o_q[c] <= 8'd1;
        else if (lv > 9'(Levels)) level_o_q[c] <= Levels;
        else level_o_q[c] <= lv[7:0];
      end
    end
  end

  assign out_valid_o   = out_v_q;
  assign raw_red_o     = raw_o_q[2];
  assign raw_green_o   = raw_o_q[1];
  assign raw_blue_o    = raw_o_q[0];
  assign duty_red_o    = duty_o_q[2];
  assign duty_green_o  = duty_o_q[1];
  assign duty_blue_o   = duty_o_q[0];
  assign level_red_o   = level_o_q[2];
  assign level_green_o = level_o_q[1];
  assign level_blue_o  = level_o_q[0];
  assign stays_dark_o  = dark_o_q;

`ifndef SYNTH
  a_disabled_dark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !en_q) |-> (duty_o_q == '0 && level_o_q == '0 && stays_dark_o))
    else $error("disabled output is not dark");

  a_level_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (level_red_o <= Levels && level_green_o <= Levels &&
                     level_blue_o <= Levels))
    else $error("PWM level above range");

  a_level_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && duty_red_o != 8'd0) |-> (level_red_o != 8'd0))
    else $error("nonzero duty quantized to level zero");
`endif

endmodule
